### design/dwpa_pkg.sv
// Shared constants, widths and helpers for the daily window periodic alarm.
// No dependencies; imported by dwpa_mod and daily_window_periodic_alarm_core.
package dwpa_pkg;

    localparam int NOW_W = 17;
    localparam int MIN_W = 11;
    localparam int RUN_W = 17;
    localparam int SEC_W = 17;
    localparam int EXT_W = 19;
    localparam int IDX_W = 2;
    localparam int CNT_W = $clog2(SEC_W + 1);

    localparam logic [IDX_W-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_END   = 2'd1;
    localparam logic [IDX_W-1:0] REG_PERIOD       = 2'd2;
    localparam logic [IDX_W-1:0] REG_RUN_SECONDS  = 2'd3;

    localparam logic [EXT_W-1:0] DAY_SECONDS   = 19'd86400;
    localparam logic [SEC_W-1:0] DEFAULT_SLEEP = 17'd60;
    localparam logic [MIN_W-1:0] PERIOD_RESET  = 11'd60;

    // minutes to seconds: m*64 - m*4
    function automatic logic [EXT_W-1:0] to_sec(input logic [MIN_W-1:0] m);
        logic [EXT_W-1:0] mx;
        mx = {{(EXT_W-MIN_W){1'b0}}, m};
        return (mx << 6) - (mx << 2);
    endfunction

    function automatic logic [SEC_W-1:0] cap_day(input logic [EXT_W-1:0] x);
        if (x > DAY_SECONDS) begin
            return DAY_SECONDS[SEC_W-1:0];
        end
        return x[SEC_W-1:0];
    endfunction

endpackage

### design/daily_window_periodic_alarm_core.sv
// Top level of the daily window periodic alarm: config registers, sequencer, result register.
// Depends on dwpa_pkg and dwpa_mod.
//
// Each request takes the second of the day and answers whether it falls in the daily
// window, whether a run slot starts there, and how long to sleep. A request inside the
// window with a nonzero period is classified while the serial remainder unit is loaded,
// then takes 17 steps of that unit; the sequencer then sees it finish and loads the
// result once the output register is free; other requests skip the unit. One request
// is processed at a time (s_ready is high only when idle, from the cycle after the
// result is loaded), so no new request is taken until the result is loaded; a finished
// result waits in the output register. Config writes are always taken and should be
// made only while the block is idle.
module daily_window_periodic_alarm_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [dwpa_pkg::NOW_W-1:0] s_now_second,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_run_now,
    output logic                       m_in_window,
    output logic [dwpa_pkg::SEC_W-1:0] m_sleep_seconds,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dwpa_pkg::IDX_W-1:0] cfg_index,
    input  logic [dwpa_pkg::RUN_W-1:0] cfg_data
);
    import dwpa_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLASS = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [MIN_W-1:0] start_reg, end_reg, period_reg;
    logic [RUN_W-1:0] run_reg;
    logic [NOW_W-1:0] now_reg;
    logic [SEC_W-1:0] off_reg, off_next;
    logic [SEC_W-1:0] len_reg, len_next;
    logic [SEC_W-1:0] p_reg, p_next;
    logic             div_reg, div_next;
    logic             inw_reg, inw_next;
    logic [SEC_W-1:0] sleep_reg, sleep_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_run_reg, m_run_next;
    logic             m_inw_reg, m_inw_next;
    logic [SEC_W-1:0] m_sleep_reg, m_sleep_next;

    logic [EXT_W-1:0] s_sec, e_sec, p_sec, n_ext;
    logic [EXT_W-1:0] c_off, c_len;
    logic             c_inw;
    logic [SEC_W-1:0] c_sleep;
    logic             div_start, div_done;
    logic [SEC_W-1:0] div_rem;
    logic [EXT_W-1:0] reach, p_ext, rem_ext, run_ext;
    logic             f_run;
    logic [SEC_W-1:0] f_sleep;
    logic             out_free;

    dwpa_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (off_next),
        .denom   (p_next),
        .done    (div_done),
        .rem     (div_rem)
    );

    // classify against the window
    always_comb begin
        s_sec   = to_sec(start_reg);
        e_sec   = to_sec(end_reg);
        p_sec   = to_sec(period_reg);
        n_ext   = {{(EXT_W-NOW_W){1'b0}}, now_reg};
        c_inw   = 1'b0;
        c_sleep = DEFAULT_SLEEP;
        c_off   = '0;
        c_len   = '0;
        if (s_sec < e_sec) begin
            if (n_ext < s_sec) begin
                c_sleep = cap_day(s_sec - n_ext);
            end else if (n_ext <= e_sec) begin
                c_inw = 1'b1;
                c_off = n_ext - s_sec;
                c_len = e_sec - s_sec;
            end else if (n_ext < s_sec + DAY_SECONDS) begin
                c_sleep = cap_day(s_sec + DAY_SECONDS - n_ext);
            end
        end else if (s_sec > e_sec) begin
            if ((n_ext + DAY_SECONDS >= s_sec) && (n_ext <= e_sec)) begin
                c_inw = 1'b1;
                c_off = n_ext + DAY_SECONDS - s_sec;
                c_len = e_sec + DAY_SECONDS - s_sec;
            end else if ((n_ext > e_sec) && (n_ext < s_sec)) begin
                c_sleep = cap_day(s_sec - n_ext);
            end else if ((n_ext >= s_sec) && (n_ext <= e_sec + DAY_SECONDS)) begin
                c_inw = 1'b1;
                c_off = n_ext - s_sec;
                c_len = e_sec + DAY_SECONDS - s_sec;
            end
        end
    end

    // slot result from the remainder
    always_comb begin
        p_ext   = {{(EXT_W-SEC_W){1'b0}}, p_reg};
        rem_ext = {{(EXT_W-SEC_W){1'b0}}, div_rem};
        run_ext = {{(EXT_W-RUN_W){1'b0}}, run_reg};
        reach   = {{(EXT_W-SEC_W){1'b0}}, off_reg} + p_ext - rem_ext;
        f_run   = 1'b0;
        f_sleep = DEFAULT_SLEEP;
        if (reach > {{(EXT_W-SEC_W){1'b0}}, len_reg}) begin
            f_sleep = DEFAULT_SLEEP;
        end else if (div_rem == '0) begin
            f_run   = 1'b1;
            f_sleep = (p_ext > run_ext) ? cap_day(p_ext - run_ext) : '0;
        end else begin
            f_sleep = cap_day(p_ext - rem_ext);
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == ST_CLASS) && div_next;

    always_comb begin
        state_next   = state_reg;
        off_next     = off_reg;
        len_next     = len_reg;
        p_next       = p_reg;
        div_next     = div_reg;
        inw_next     = inw_reg;
        sleep_next   = sleep_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_run_next   = m_run_reg;
        m_inw_next   = m_inw_reg;
        m_sleep_next = m_sleep_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS: begin
                off_next   = c_off[SEC_W-1:0];
                len_next   = c_len[SEC_W-1:0];
                p_next     = p_sec[SEC_W-1:0];
                inw_next   = c_inw;
                sleep_next = c_sleep;
                div_next   = c_inw && (period_reg != '0);
                state_next = div_next ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_inw_next   = inw_reg;
                    m_run_next   = div_reg && f_run;
                    m_sleep_next = div_reg ? f_sleep : sleep_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            start_reg   <= '0;
            end_reg     <= '0;
            period_reg  <= PERIOD_RESET;
            run_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_WINDOW_START: start_reg  <= cfg_data[MIN_W-1:0];
                    REG_WINDOW_END:   end_reg    <= cfg_data[MIN_W-1:0];
                    REG_PERIOD:       period_reg <= cfg_data[MIN_W-1:0];
                    REG_RUN_SECONDS:  run_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
        if (s_valid && s_ready) begin
            now_reg <= s_now_second;
        end
        off_reg     <= off_next;
        len_reg     <= len_next;
        p_reg       <= p_next;
        div_reg     <= div_next;
        inw_reg     <= inw_next;
        sleep_reg   <= sleep_next;
        m_run_reg   <= m_run_next;
        m_inw_reg   <= m_inw_next;
        m_sleep_reg <= m_sleep_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_run_now       = m_run_reg;
    assign m_in_window     = m_inw_reg;
    assign m_sleep_seconds = m_sleep_reg;

endmodule

### design/dwpa_mod.sv
// Iterative restoring remainder unit: one trial subtract per cycle.
// Depends on dwpa_pkg.
module dwpa_mod (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [dwpa_pkg::SEC_W-1:0] numer,
    input  logic [dwpa_pkg::SEC_W-1:0] denom,
    output logic                       done,
    output logic [dwpa_pkg::SEC_W-1:0] rem
);
    import dwpa_pkg::*;

    logic [SEC_W-1:0] num_reg, num_next;
    logic [SEC_W-1:0] den_reg, den_next;
    logic [SEC_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SEC_W:0]   shifted;
    logic [SEC_W+1:0] diff;

    assign shifted = {rem_reg, num_reg[SEC_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            cnt_next  = CNT_W'(SEC_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            rem_next = diff[SEC_W+1] ? shifted[SEC_W-1:0] : diff[SEC_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### test/testbench.sv
// Self-checking testbench for daily_window_periodic_alarm_core: directed table then random phases.
// Depends on dwpa_pkg and the core RTL; predicts untyped answers with its own window/slot model.
module testbench;
    import dwpa_pkg::*;

    localparam longint DAY_SEC   = 86400;
    localparam longint DFLT_WAIT = 60;
    localparam int     LIMIT     = 400000;
    localparam int     PHASES    = 15;
    localparam int     PER_PHASE = 100;

    typedef struct packed {
        logic             run_now;
        logic             in_window;
        logic [SEC_W-1:0] sleep_seconds;
    } alarm_ans_t;

    typedef struct packed {
        logic             is_reg;
        logic [IDX_W-1:0] idx;
        logic [NOW_W-1:0] value;
        logic             typed;
        alarm_ans_t       want;
    } plan_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [NOW_W-1:0] s_now_second = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_run_now;
    logic             m_in_window;
    logic [SEC_W-1:0] m_sleep_seconds;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [RUN_W-1:0] cfg_data = '0;

    // shadow copy of the register file
    logic [MIN_W-1:0] win_start = '0;
    logic [MIN_W-1:0] win_end = '0;
    logic [MIN_W-1:0] period = PERIOD_RESET;
    logic [RUN_W-1:0] run_len = '0;

    alarm_ans_t pending_answers[$];
    plan_row_t  plan[$];
    bit         no_idle = 1'b0;
    int         errors = 0;
    int         cycles = 0;
    int         n_answers = 0;
    int         n_runs = 0;
    int         n_inside = 0;
    int         n_settings = 0;

    daily_window_periodic_alarm_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_now_second   (s_now_second),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_run_now      (m_run_now),
        .m_in_window    (m_in_window),
        .m_sleep_seconds(m_sleep_seconds),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d answers pending", cycles,
                     pending_answers.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint clamp_day(input longint v);
        if (v < 0) return 0;
        if (v > DAY_SEC) return DAY_SEC;
        return v;
    endfunction

    function automatic alarm_ans_t slot_answer(input longint now, input longint lo,
                                               input longint hi, input longint p);
        alarm_ans_t a;
        longint     full, off, k;
        a.run_now = 1'b0;
        a.in_window = 1'b1;
        a.sleep_seconds = 17'(DFLT_WAIT);
        if (p == 0) return a;
        full = (hi - lo) / p;
        off = now - lo;
        k = off / p;
        if (k >= full) return a;
        if (off == k * p) begin
            a.run_now = 1'b1;
            a.sleep_seconds = 17'(clamp_day(p - longint'(run_len)));
        end else begin
            a.sleep_seconds = 17'(clamp_day((k + 1) * p - off));
        end
        return a;
    endfunction

    function automatic alarm_ans_t predict_alarm(input logic [NOW_W-1:0] now_in);
        alarm_ans_t a;
        longint     now, s, e, p;
        now = longint'(now_in);
        s = longint'(win_start) * 60;
        e = longint'(win_end) * 60;
        p = longint'(period) * 60;
        a.run_now = 1'b0;
        a.in_window = 1'b0;
        a.sleep_seconds = 17'(DFLT_WAIT);
        if (s < e) begin
            if (now < s) a.sleep_seconds = 17'(clamp_day(s - now));
            else if (now <= e) a = slot_answer(now, s, e, p);
            else if (now < s + DAY_SEC) a.sleep_seconds = 17'(clamp_day(s + DAY_SEC - now));
        end else if (s > e) begin
            if (now >= s - DAY_SEC && now <= e) a = slot_answer(now, s - DAY_SEC, e, p);
            else if (now > e && now < s) a.sleep_seconds = 17'(clamp_day(s - now));
            else if (now >= s && now <= e + DAY_SEC) a = slot_answer(now, s, e + DAY_SEC, p);
        end
        return a;
    endfunction

    function automatic int idle_draw();
        return no_idle ? 0 : int'($urandom_range(0, 11));
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RUN_W-1:0] data);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_WINDOW_START: win_start = data[MIN_W-1:0];
            REG_WINDOW_END:   win_end = data[MIN_W-1:0];
            REG_PERIOD:       period = data[MIN_W-1:0];
            REG_RUN_SECONDS:  run_len = data;
            default: ;
        endcase
    endtask

    task automatic send_query(input logic [NOW_W-1:0] now, input logic typed,
                              input alarm_ans_t want);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_now_second <= now;
        do @(posedge aclk); while (!s_ready);
        pending_answers.push_back(typed ? want : predict_alarm(now));
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic add_reg(input logic [IDX_W-1:0] idx, input logic [NOW_W-1:0] data);
        plan.push_back('{1'b1, idx, data, 1'b0, alarm_ans_t'(0)});
    endtask

    task automatic add_query(input logic [NOW_W-1:0] now, input logic typed,
                             input logic run, input logic inw, input int sleep);
        plan.push_back('{1'b0, REG_WINDOW_START, now, typed, alarm_ans_t'({run, inw, 17'(sleep)})});
    endtask

    function automatic logic [NOW_W-1:0] pick_now();
        longint s, e, p, v;
        int     r;
        s = longint'(win_start) * 60;
        e = longint'(win_end) * 60;
        p = longint'(period) * 60;
        r = $urandom_range(0, 99);
        if (r < 10) return 17'($urandom_range(0, 131071));
        if (r < 20) return 17'($urandom_range(0, 86399));
        if (r < 32) begin
            case ($urandom_range(0, 6))
                0: v = 0;
                1: v = DAY_SEC - 1;
                2: v = s;
                3: v = e;
                4: v = e + 1;
                5: v = s - 1;
                default: v = DAY_SEC;
            endcase
        end else begin
            v = s;
            if (p > 0) v = s + longint'($urandom_range(0, 86400 / p + 1)) * p;
            case ($urandom_range(0, 5))
                0: v = v - 1;
                1: v = v + 1;
                2: if (p > 0) v = v + longint'($urandom_range(0, p - 1));
                default: ;
            endcase
            while (v >= DAY_SEC) v = v - DAY_SEC;
        end
        if (v < 0) v = 0;
        if (v > 131071) v = 131071;
        return 17'(v);
    endfunction

    function automatic logic [MIN_W-1:0] pick_minute();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 11'($urandom_range(0, 2047));
        if (r < 20) return ($urandom_range(0, 1) != 0) ? 11'd1439 : 11'd0;
        return 11'($urandom_range(0, 1439));
    endfunction

    task automatic random_setting();
        logic [MIN_W-1:0] st, en, pe;
        logic [RUN_W-1:0] rn;
        int               r;
        st = pick_minute();
        en = ($urandom_range(0, 99) < 12) ? st : pick_minute();
        r = $urandom_range(0, 99);
        if (r < 5) pe = 11'd0;
        else if (r < 10) pe = 11'd1440;
        else if (r < 15) pe = 11'($urandom_range(0, 2047));
        else if (r < 25) pe = 11'd1;
        else if (r < 60) pe = 11'($urandom_range(1, 30));
        else pe = 11'($urandom_range(1, 240));
        r = $urandom_range(0, 99);
        if (r < 10) rn = 17'($urandom_range(0, 131071));
        else if (r < 20) rn = '0;
        else if (r < 30) rn = 17'd86400;
        else rn = 17'($urandom_range(0, int'(pe) * 60 + 120));
        write_reg(REG_WINDOW_START, 17'(st));
        write_reg(REG_WINDOW_END, 17'(en));
        write_reg(REG_PERIOD, 17'(pe));
        write_reg(REG_RUN_SECONDS, rn);
    endtask

    // result side: random back-pressure per answer
    initial begin
        int stall;
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        alarm_ans_t want;
        if (aresetn && m_valid && m_ready) begin
            n_answers <= n_answers + 1;
            if (m_run_now) n_runs <= n_runs + 1;
            if (m_in_window) n_inside <= n_inside + 1;
            if (pending_answers.size() == 0) begin
                $display("%0t: answer with none expected: run %0d in %0d sleep %0d",
                         $time, m_run_now, m_in_window, m_sleep_seconds);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (m_run_now !== want.run_now) begin
                    $display("%0t: run_now expected %0d got %0d", $time, want.run_now, m_run_now);
                    errors++;
                end
                if (m_in_window !== want.in_window) begin
                    $display("%0t: in_window expected %0d got %0d", $time, want.in_window,
                             m_in_window);
                    errors++;
                end
                if (m_sleep_seconds !== want.sleep_seconds) begin
                    $display("%0t: sleep_seconds expected %0d got %0d", $time,
                             want.sleep_seconds, m_sleep_seconds);
                    errors++;
                end
            end
        end
    end

    initial begin
        bit last_query;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // equal start and end after reset
        add_query(17'd0, 1'b1, 1'b0, 1'b0, 60);
        add_query(17'd86399, 1'b1, 1'b0, 1'b0, 60);
        add_query(17'd131071, 1'b1, 1'b0, 1'b0, 60);
        // plain window 08:00-18:00, hourly
        add_reg(REG_WINDOW_START, 17'd480);
        add_reg(REG_WINDOW_END, 17'd1080);
        add_reg(REG_PERIOD, 17'd60);
        add_reg(REG_RUN_SECONDS, 17'd300);
        add_query(17'd0, 1'b1, 1'b0, 1'b0, 28800);
        add_query(17'd28800, 1'b1, 1'b1, 1'b1, 3300);
        add_query(17'd28801, 1'b1, 1'b0, 1'b1, 3599);
        add_query(17'd64800, 1'b1, 1'b0, 1'b1, 60);
        add_query(17'd64801, 1'b1, 1'b0, 1'b0, 50399);
        add_query(17'd86399, 1'b1, 1'b0, 1'b0, 28801);
        add_query(17'd131071, 1'b1, 1'b0, 1'b0, 60);
        add_query(17'd39600, 1'b0, 1'b0, 1'b0, 0);
        add_reg(REG_RUN_SECONDS, 17'd131071);
        add_query(17'd28800, 1'b1, 1'b1, 1'b1, 0);
        // wrapped window 23:00-02:00, half hourly
        add_reg(REG_WINDOW_START, 17'd1380);
        add_reg(REG_WINDOW_END, 17'd120);
        add_reg(REG_PERIOD, 17'd30);
        add_query(17'd0, 1'b1, 1'b1, 1'b1, 0);
        add_query(17'd7200, 1'b1, 1'b0, 1'b1, 60);
        add_query(17'd7201, 1'b1, 1'b0, 1'b0, 75599);
        add_query(17'd82800, 1'b1, 1'b1, 1'b1, 0);
        add_query(17'd86399, 1'b1, 1'b0, 1'b1, 1);
        add_reg(REG_RUN_SECONDS, 17'd0);
        add_reg(REG_PERIOD, 17'd0);
        add_query(17'd82800, 1'b1, 1'b0, 1'b1, 60);
        // period longer than the window: no full slot
        add_reg(REG_WINDOW_START, 17'd0);
        add_reg(REG_WINDOW_END, 17'd1439);
        add_reg(REG_PERIOD, 17'd2047);
        add_query(17'd0, 1'b1, 1'b0, 1'b1, 60);
        add_query(17'd86340, 1'b1, 1'b0, 1'b1, 60);
        add_query(17'd86341, 1'b1, 1'b0, 1'b0, 59);
        // start beyond a day
        add_reg(REG_WINDOW_START, 17'd2047);
        add_reg(REG_WINDOW_END, 17'd0);
        add_query(17'd1, 1'b1, 1'b0, 1'b0, 86400);
        add_query(17'd0, 1'b1, 1'b0, 1'b0, 60);
        add_query(17'd131071, 1'b1, 1'b0, 1'b0, 60);

        last_query = 1'b1;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (last_query) begin
                    s_valid <= 1'b0;
                    wait_drained();
                    n_settings++;
                end
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                if (!last_query) cfg_valid <= 1'b0;
                send_query(plan[i].value, plan[i].typed, plan[i].want);
            end
            last_query = !plan[i].is_reg;
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            s_valid <= 1'b0;
            wait_drained();
            no_idle = (ph % 4 == 3);
            random_setting();
            n_settings++;
            cfg_valid <= 1'b0;
            for (int q = 0; q < PER_PHASE; q++)
                send_query(pick_now(), 1'b0, alarm_ans_t'(0));
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge aclk);
        $display("Covered %0d answers: %0d run slots, %0d inside the window", n_answers,
                 n_runs, n_inside);
        $display("over %0d register settings with random stalls on both channels", n_settings);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
design/dwpa_pkg.sv
design/dwpa_mod.sv
design/daily_window_periodic_alarm_core.sv
test/testbench.sv
